FILE: hdl/mbe_pkg.sv
package mbe_pkg;

   localparam int COORD_BITS    = 12;
   localparam int FRAC_BITS_DEF = 56;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [15:0] MAX_ITER_RST = 16'd50;
   localparam logic [23:0] COLOR_STEP   = 24'hff0100;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } mbe_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic [31:0]           pixel_color;
      logic [15:0]           escape_count;
   } mbe_rsp_type;

   typedef struct packed {
      logic [15:0]        max_iterations;
      logic [62:0]        pixel_scale;
      logic signed [63:0] offset_real;
      logic signed [63:0] offset_imag;
   } mbe_cfg_type;

   // operand pair / destination of one shared multiply
   typedef enum logic [2:0] {
      OP_CX,
      OP_CY,
      OP_RI,
      OP_RR,
      OP_II
   } mbe_op_type;

   typedef struct packed {
      logic       start;
      mbe_op_type op;
      logic       mul_load;
      logic       mul_pp;
      logic [1:0] pp_idx;
      logic       mul_finish;
      logic       offs;
      logic       upd_a;
      logic       upd_b;
      logic       load_out;
   } mbe_cmd_type;

   typedef struct packed {
      logic mag_ge_four;
      logic count_ge_max;
   } mbe_sts_type;

endpackage

FILE: hdl/mandelbrot_escape_time_pixel_core.sv
// One item is worked on at a time: req_stall is high until the sequencer is back in idle.
// One 32x32 multiplier is shared; each 64-bit product is built from four partial products,
// and each iteration takes three products plus two add steps and a check.
// The next item is accepted while the previous result waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle, empties the output
// and loads the registers with limit 50, scale 1.0 and zero offsets.
module mandelbrot_escape_time_pixel_core #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mbe_pkg::mbe_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mbe_pkg::mbe_rsp_type              rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import mbe_pkg::*;

   mbe_cfg_type cfg;
   mbe_cmd_type cmd;
   mbe_sts_type sts;

   mbe_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .sts      (sts)
   );

endmodule

FILE: hdl/mbe_csr.sv
module mbe_csr #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output mbe_pkg::mbe_cfg_type              cfg
);
   import mbe_pkg::*;

   localparam logic [1:0] REG_MAX_ITER = 2'd0;
   localparam logic [1:0] REG_SCALE    = 2'd1;
   localparam logic [1:0] REG_OFF_RE   = 2'd2;
   localparam logic [1:0] REG_OFF_IM   = 2'd3;

   mbe_cfg_type cfg_ff;
   logic [1:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations <= MAX_ITER_RST;
         cfg_ff.pixel_scale    <= 63'(1) << FRAC_BITS;
         cfg_ff.offset_real    <= '0;
         cfg_ff.offset_imag    <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MAX_ITER: cfg_ff.max_iterations <= csr_pwdata[15:0];
            REG_SCALE:    cfg_ff.pixel_scale    <= csr_pwdata[62:0];
            REG_OFF_RE:   cfg_ff.offset_real    <= csr_pwdata;
            REG_OFF_IM:   cfg_ff.offset_imag    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAX_ITER: csr_prdata = {48'd0, cfg_ff.max_iterations};
         REG_SCALE:    csr_prdata = {1'b0, cfg_ff.pixel_scale};
         REG_OFF_RE:   csr_prdata = cfg_ff.offset_real;
         REG_OFF_IM:   csr_prdata = cfg_ff.offset_imag;
         default:      csr_prdata = '0;
      endcase
   end

endmodule

FILE: hdl/mbe_ctrl.sv
module mbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mbe_pkg::mbe_sts_type sts,
   output mbe_pkg::mbe_cmd_type cmd
);
   import mbe_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CX,
      S_CY,
      S_OFFS,
      S_RI,
      S_UPA,
      S_UPB,
      S_RR,
      S_II,
      S_CHK,
      S_DONE
   } state_type;

   // phase 0 loads operands, 1..4 issue partial products, 6 writes the result
   localparam logic [2:0] PH_LAST = 3'd6;

   state_type  state_ff;
   logic [2:0] phase_ff;
   logic       rsp_valid_ff;
   logic       is_mul;
   logic       out_free;

   assign is_mul    = (state_ff inside {S_CX, S_CY, S_RI, S_RR, S_II});
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.op         = OP_CX;
      cmd.start      = (state_ff == S_IDLE) && req_valid;
      cmd.mul_load   = is_mul && (phase_ff == 3'd0);
      cmd.mul_pp     = is_mul && (phase_ff inside {[3'd1:3'd4]});
      cmd.pp_idx     = 2'(phase_ff - 3'd1);
      cmd.mul_finish = is_mul && (phase_ff == PH_LAST);
      cmd.offs       = (state_ff == S_OFFS);
      cmd.upd_a      = (state_ff == S_UPA);
      cmd.upd_b      = (state_ff == S_UPB);
      cmd.load_out   = (state_ff == S_DONE) && out_free;
      case (state_ff)
         S_CY:    cmd.op = OP_CY;
         S_RI:    cmd.op = OP_RI;
         S_RR:    cmd.op = OP_RR;
         S_II:    cmd.op = OP_II;
         default: cmd.op = OP_CX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;

         if (is_mul)
            phase_ff <= (phase_ff == PH_LAST) ? 3'd0 : phase_ff + 3'd1;

         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_CX;
            S_CX:   if (phase_ff == PH_LAST) state_ff <= S_CY;
            S_CY:   if (phase_ff == PH_LAST) state_ff <= S_OFFS;
            S_OFFS: state_ff <= S_RI;
            S_RI:   if (phase_ff == PH_LAST) state_ff <= S_UPA;
            S_UPA:  state_ff <= S_UPB;
            S_UPB:  state_ff <= S_RR;
            S_RR:   if (phase_ff == PH_LAST) state_ff <= S_II;
            S_II:   if (phase_ff == PH_LAST) state_ff <= S_CHK;
            S_CHK: begin
               if (sts.mag_ge_four || sts.count_ge_max)
                  state_ff <= S_DONE;
               else
                  state_ff <= S_RI;
            end
            S_DONE: if (out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: hdl/mbe_datapath.sv
module mbe_datapath #(
   parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  mbe_pkg::mbe_cmd_type cmd,
   input  mbe_pkg::mbe_cfg_type cfg,
   input  mbe_pkg::mbe_req_type req_data,
   output mbe_pkg::mbe_rsp_type rsp_data,
   output mbe_pkg::mbe_sts_type sts
);
   import mbe_pkg::*;

   localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] SAT_MIN = {1'b1, 63'd0};
   localparam logic [63:0] FOUR    = 64'(4) << FRAC_BITS;

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         return s[64] ? SAT_MIN : SAT_MAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63])
         return s[64] ? SAT_MIN : SAT_MAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] magn(input logic [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   // truncate the magnitude product toward zero, then saturate
   function automatic logic [63:0] fx_finish(input logic [127:0] p, input logic neg);
      logic [127:0] sh;
      sh = p >> FRAC_BITS;
      if (|sh[127:64])
         return neg ? SAT_MIN : SAT_MAX;
      if (!neg)
         return sh[63] ? SAT_MAX : sh[63:0];
      if (sh[63])
         return SAT_MIN;
      return ~sh[63:0] + 64'd1;
   endfunction

   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [63:0]  cr_ff, ci_ff, zr_ff, zi_ff, rr_ff, ii_ff, ri_ff;
   logic [15:0]  count_ff;
   logic [63:0]  ua_ff, ub_ff;
   logic         neg_ff;
   logic [63:0]  pp_ff;
   logic         pp_vld_ff;
   logic [1:0]   pp_idx_ff;
   logic [127:0] acc_ff;
   mbe_rsp_type  rsp_ff;

   logic [63:0]  op_a, op_b;
   logic [31:0]  pa, pb;
   logic [127:0] pp_shifted;
   logic [63:0]  fx_res, raw_res, mul_res;
   logic [63:0]  mag;
   logic [39:0]  color_full;

   always_comb begin
      case (cmd.op)
         OP_CX: begin
            op_a = 64'(px_ff);
            op_b = {1'b0, cfg.pixel_scale};
         end
         OP_CY: begin
            op_a = 64'(py_ff);
            op_b = {1'b0, cfg.pixel_scale};
         end
         OP_RI: begin
            op_a = zr_ff;
            op_b = zi_ff;
         end
         OP_RR: begin
            op_a = zr_ff;
            op_b = zr_ff;
         end
         OP_II: begin
            op_a = zi_ff;
            op_b = zi_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
   assign pa = cmd.pp_idx[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign pb = cmd.pp_idx[0] ? ub_ff[63:32] : ub_ff[31:0];

   always_comb begin
      case (pp_idx_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd3:    pp_shifted = {pp_ff, 64'd0};
         default: pp_shifted = {32'd0, pp_ff, 32'd0};
      endcase
   end

   assign fx_res  = fx_finish(acc_ff, neg_ff);
   // scaled coordinate: unsigned product, clamp above the largest positive value
   assign raw_res = (|acc_ff[127:63]) ? SAT_MAX : acc_ff[63:0];
   assign mul_res = (cmd.op == OP_CX || cmd.op == OP_CY) ? raw_res : fx_res;

   assign mag            = sat_add(rr_ff, ii_ff);
   assign sts.mag_ge_four  = !mag[63] && (mag >= FOUR);
   assign sts.count_ge_max = (count_ff >= cfg.max_iterations);

   assign color_full = {24'd0, count_ff} * {16'd0, COLOR_STEP};
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff    <= req_data.pixel_x;
         py_ff    <= req_data.pixel_y;
         zr_ff    <= '0;
         zi_ff    <= '0;
         rr_ff    <= '0;
         ii_ff    <= '0;
         count_ff <= '0;
      end

      if (cmd.mul_load) begin
         ua_ff  <= magn(op_a);
         ub_ff  <= magn(op_b);
         neg_ff <= op_a[63] ^ op_b[63];
         acc_ff <= '0;
      end else if (pp_vld_ff) begin
         acc_ff <= acc_ff + pp_shifted;
      end

      pp_vld_ff <= cmd.mul_pp;
      pp_idx_ff <= cmd.pp_idx;
      if (cmd.mul_pp)
         pp_ff <= pa * pb;

      if (cmd.mul_finish) begin
         case (cmd.op)
            OP_CX:   cr_ff <= mul_res;
            OP_CY:   ci_ff <= mul_res;
            OP_RI:   ri_ff <= mul_res;
            OP_RR:   rr_ff <= mul_res;
            OP_II:   ii_ff <= mul_res;
            default: ;
         endcase
      end

      if (cmd.offs) begin
         cr_ff <= sat_sub(cr_ff, cfg.offset_real);
         ci_ff <= sat_sub(ci_ff, cfg.offset_imag);
      end

      // rr and ri are recomputed later in the pass, so they hold the partial sums
      if (cmd.upd_a) begin
         rr_ff <= sat_sub(rr_ff, ii_ff);
         ri_ff <= sat_add(ri_ff, ri_ff);
      end

      if (cmd.upd_b) begin
         zr_ff    <= sat_add(rr_ff, cr_ff);
         zi_ff    <= sat_add(ri_ff, ci_ff);
         count_ff <= count_ff + 16'd1;
      end

      if (cmd.load_out) begin
         rsp_ff.out_x        <= px_ff;
         rsp_ff.out_y        <= py_ff;
         rsp_ff.pixel_color  <= (count_ff == cfg.max_iterations) ? 32'd0
                                                                 : color_full[31:0];
         rsp_ff.escape_count <= count_ff;
      end
   end

endmodule
